[hw/rtl/pfns_pkg.sv]
// ----------------------------------------------------------------------------
// pfns_pkg
// Shared types and constants of the pitch frame note segmenter.
// ----------------------------------------------------------------------------
package pfns_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int OUT_DEPTH   = 4;

	localparam logic [15:0] THRESHOLD_RESET = 16'd26214;
	localparam logic [15:0] MIN_HOPS_RESET  = 16'd3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CONF_THRESHOLD = 2'd0,
		REG_MIN_NOTE_HOPS  = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		ACT_FRAME = 1'b0,
		ACT_END   = 1'b1
	} action_t;

	typedef struct packed {
		logic              action;
		logic signed [7:0] pitch;
		logic [15:0]       confidence;
	} frame_t;

	typedef struct packed {
		logic [23:0] onset_hop;
		logic [23:0] offset_hop;
		logic [6:0]  note_pitch;
		logic [15:0] peak_confidence;
		logic        last_of_run;
	} note_t;

	typedef struct packed {
		logic [15:0] conf_threshold;
		logic [15:0] min_note_hops;
	} cfg_t;

	// up to two results per request go into the result queue at once
	typedef struct packed {
		logic [1:0] n;
		note_t      first;
		note_t      second;
	} push_t;

endpackage

[hw/rtl/pfns_stream_if.sv]
// ----------------------------------------------------------------------------
// pfns_stream_if
// Valid/ready stream channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface pfns_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/pfns_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pfns_cfg_regs
// Configuration registers: confidence threshold and minimum note length.
// ----------------------------------------------------------------------------
module pfns_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pfns_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pfns_pkg::CFG_DATA_W-1:0]  cfg_data,
	output pfns_pkg::cfg_t                   cfg
);

	logic [15:0] threshold_q;
	logic [15:0] min_hops_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= pfns_pkg::THRESHOLD_RESET;
			min_hops_q  <= pfns_pkg::MIN_HOPS_RESET;
		end else if (cfg_we) begin
			case (pfns_pkg::cfg_reg_t'(cfg_index))
				pfns_pkg::REG_CONF_THRESHOLD: begin
					threshold_q <= cfg_data;
				end
				pfns_pkg::REG_MIN_NOTE_HOPS: begin
					min_hops_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.conf_threshold = threshold_q;
	assign cfg.min_note_hops  = min_hops_q;

endmodule

[hw/rtl/pfns_core.sv]
// ----------------------------------------------------------------------------
// pfns_core
// Input register, run and pending-note tracking, result generation.
// ----------------------------------------------------------------------------
module pfns_core #(
	parameter int TIME_BITS = 24,
	parameter int CONF_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfns_pkg::cfg_t      cfg,
	pfns_stream_if.sink         frames,
	input  logic                room,
	output pfns_pkg::push_t     push
);

	localparam int TW   = TIME_BITS;
	localparam int LW   = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam int CMPW = (CONF_BITS > 16) ? CONF_BITS : 16;
	localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

	function automatic logic long_enough(input logic [TW-1:0] on, input logic [TW-1:0] off,
			input logic [15:0] min_hops);
		logic [TW-1:0] len;
		len = (off >= on) ? off - on : '0;
		return LW'(len) >= LW'(min_hops);
	endfunction

	function automatic pfns_pkg::note_t make_note(input logic [6:0] p,
			input logic [TW-1:0] on, input logic [TW-1:0] off,
			input logic [CONF_BITS-1:0] pk, input logic last);
		pfns_pkg::note_t r;
		r.onset_hop       = 24'(on);
		r.offset_hop      = 24'(off);
		r.note_pitch      = p;
		r.peak_confidence = 16'(pk);
		r.last_of_run     = last;
		return r;
	endfunction

	// input register
	logic             valid_s1;
	pfns_pkg::frame_t item_s1;
	logic             proc;

	// segmenter state
	logic [TW-1:0]        frame_count_q;
	logic                 run_active_q;
	logic [6:0]           run_pitch_q;
	logic [TW-1:0]        run_onset_q;
	logic [TW-1:0]        run_offset_q;
	logic [CONF_BITS-1:0] run_peak_q;
	logic                 held_valid_q;
	logic [6:0]           held_pitch_q;
	logic [TW-1:0]        held_onset_q;
	logic [TW-1:0]        held_offset_q;
	logic [CONF_BITS-1:0] held_peak_q;

	logic                 is_end;
	logic [CONF_BITS-1:0] conf;
	logic [TW-1:0]        end_hop;
	logic                 voiced;
	logic                 cont;
	logic                 close;
	logic                 merge;
	logic [CONF_BITS-1:0] merged_peak;
	logic                 emit_a;
	logic                 emit_b;
	logic                 held2_valid;
	logic [6:0]           held2_pitch;
	logic [TW-1:0]        held2_onset;
	logic [TW-1:0]        held2_offset;
	logic [CONF_BITS-1:0] held2_peak;

	assign proc         = valid_s1 && room;
	assign frames.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.ready && frames.valid) begin
			item_s1 <= frames.payload;
		end
	end

	always_comb begin
		is_end  = (pfns_pkg::action_t'(item_s1.action) == pfns_pkg::ACT_END);
		conf    = CONF_BITS'(item_s1.confidence);
		end_hop = (frame_count_q != TIME_MAX) ? frame_count_q + TW'(1) : TIME_MAX;
		voiced  = !item_s1.pitch[7]
			&& (CMPW'(conf) >= CMPW'(cfg.conf_threshold));
		cont    = voiced && run_active_q && (item_s1.pitch[6:0] == run_pitch_q);
		close   = run_active_q && (is_end || !cont);

		// a run one hop or less after the pending note of the same pitch extends it
		merge = held_valid_q && (held_pitch_q == run_pitch_q)
			&& ({1'b0, run_onset_q} <= ({1'b0, held_offset_q} + (TW+1)'(1)));
		merged_peak = (run_peak_q > held_peak_q) ? run_peak_q : held_peak_q;

		emit_a = close && !merge && held_valid_q
			&& long_enough(held_onset_q, held_offset_q, cfg.min_note_hops);

		if (close && merge) begin
			held2_valid  = 1'b1;
			held2_pitch  = held_pitch_q;
			held2_onset  = held_onset_q;
			held2_offset = run_offset_q;
			held2_peak   = merged_peak;
		end else if (close) begin
			held2_valid  = 1'b1;
			held2_pitch  = run_pitch_q;
			held2_onset  = run_onset_q;
			held2_offset = run_offset_q;
			held2_peak   = run_peak_q;
		end else begin
			held2_valid  = held_valid_q;
			held2_pitch  = held_pitch_q;
			held2_onset  = held_onset_q;
			held2_offset = held_offset_q;
			held2_peak   = held_peak_q;
		end

		emit_b = is_end && held2_valid
			&& long_enough(held2_onset, held2_offset, cfg.min_note_hops);

		push.n      = proc ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
		push.second = make_note(held2_pitch, held2_onset, held2_offset, held2_peak, 1'b1);
		if (emit_a) begin
			push.first = make_note(held_pitch_q, held_onset_q, held_offset_q, held_peak_q,
				!emit_b);
		end else begin
			push.first = push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			run_active_q  <= 1'b0;
			run_pitch_q   <= '0;
			run_onset_q   <= '0;
			run_offset_q  <= '0;
			run_peak_q    <= '0;
			held_valid_q  <= 1'b0;
			held_pitch_q  <= '0;
			held_onset_q  <= '0;
			held_offset_q <= '0;
			held_peak_q   <= '0;
		end else if (proc) begin
			if (is_end) begin
				frame_count_q <= '0;
				run_active_q  <= 1'b0;
				run_pitch_q   <= '0;
				run_onset_q   <= '0;
				run_offset_q  <= '0;
				run_peak_q    <= '0;
				held_valid_q  <= 1'b0;
				held_pitch_q  <= '0;
				held_onset_q  <= '0;
				held_offset_q <= '0;
				held_peak_q   <= '0;
			end else begin
				frame_count_q <= end_hop;
				held_valid_q  <= held2_valid;
				held_pitch_q  <= held2_pitch;
				held_onset_q  <= held2_onset;
				held_offset_q <= held2_offset;
				held_peak_q   <= held2_peak;
				if (cont) begin
					run_offset_q <= end_hop;
					if (conf > run_peak_q) begin
						run_peak_q <= conf;
					end
				end else if (voiced) begin
					run_active_q <= 1'b1;
					run_pitch_q  <= item_s1.pitch[6:0];
					run_onset_q  <= end_hop;
					run_offset_q <= end_hop;
					run_peak_q   <= conf;
				end else begin
					run_active_q <= 1'b0;
				end
			end
		end
	end

endmodule

[hw/rtl/pfns_out_fifo.sv]
// ----------------------------------------------------------------------------
// pfns_out_fifo
// Small result queue: up to two notes in per cycle, one out per cycle if ready.
// ----------------------------------------------------------------------------
module pfns_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  pfns_pkg::push_t push,
	output logic            room,
	pfns_stream_if.source   notes
);

	localparam int DEPTH = pfns_pkg::OUT_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	pfns_pkg::note_t mem_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   count_q;
	logic            pop;

	assign pop           = notes.valid && notes.ready;
	assign notes.valid   = (count_q != '0);
	assign notes.payload = mem_q[rp_q];
	// room for a two-result request regardless of the output side
	assign room          = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + PW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PW'(push.n);
			rp_q    <= rp_q + PW'(pop);
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> ((CW+1)'(count_q) + (CW+1)'(push.n) <= (CW+1)'(DEPTH)))
		else $error("result queue overflow");

	a_pair_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run))
		else $error("two-result request with wrong last marks");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(notes.valid && !notes.ready) |=> (count_q >= $past(count_q)))
		else $error("stalled result lost");
`endif

endmodule

[hw/rtl/pitch_frame_note_segmenter_top.sv]
// ----------------------------------------------------------------------------
// pitch_frame_note_segmenter_top
// Flow: a request enters the input register; its notes then enter the queue.
// Throughput: one frame per cycle while the queue has room; an end request's two
// notes leave in turn from a four-entry result queue behind the logic stage.
// Reset: arst_n clears frame count, run, pending note and queue; the two
// registers return to their defaults.
// ----------------------------------------------------------------------------
module pitch_frame_note_segmenter_top #(
	parameter int TIME_BITS = 24,
	parameter int CONF_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pfns_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pfns_pkg::CFG_DATA_W-1:0]  cfg_data,
	pfns_stream_if.sink                      frames,
	pfns_stream_if.source                    notes
);

	pfns_pkg::cfg_t  cfg;
	pfns_pkg::push_t push;
	logic            room;

	pfns_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfns_core #(
		.TIME_BITS (TIME_BITS),
		.CONF_BITS (CONF_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.frames (frames),
		.room   (room),
		.push   (push)
	);

	pfns_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.notes  (notes)
	);

endmodule
